// ===== hw/rtl/bogr_pkg.sv =====
package bogr_pkg;
  localparam int MAX_BOXES_DEF = 64;
  localparam int MAX_CELLS_DEF = 1024;
  localparam int COORD_W = 24;
  localparam int EXT_W = 23;
  localparam int WIDE_W = 40;
  localparam logic signed [WIDE_W-1:0] BOUND_INIT = 40'sd159984;
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ROW = 2'd2;
  localparam logic REG_CELL_EDGE = 1'b0;
  localparam logic REG_MARGIN = 1'b1;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v < -40'sd8388608) r = -24'sd8388608;
    else if (v > 40'sd8388607) r = 24'sd8388607;
    else r = v[COORD_W-1:0];
    return r;
  endfunction
endpackage

// ===== hw/rtl/bogr_div.sv =====
// Restoring divider: span / cell edge, one quotient bit a cycle, saturated.
module bogr_div #(
  parameter int MAX_CELLS = bogr_pkg::MAX_CELLS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  logic signed [bogr_pkg::WIDE_W-1:0] span,
  input  logic [15:0] divisor,
  output logic done,
  output logic [$clog2(MAX_CELLS+1)-1:0] count
);
  localparam int CW = $clog2(MAX_CELLS+1);
  localparam int SW = bogr_pkg::WIDE_W;
  localparam int QW = $clog2(MAX_CELLS) + 2;
  localparam int SH = 16;
  // Quotient needs SW bits at worst; count above MAX saturates so compute
  // in a reduced form: numerator chopped to QW+SH bits plus overflow flag.
  localparam int NW = QW + SH;
  logic [NW-1:0] rem;
  logic [NW-1:0] num;
  logic [QW-1:0] quo;
  logic [$clog2(NW+1)-1:0] step;
  logic busy, over, neg;
  logic [NW:0] trial;

  assign trial = {rem[NW-2:0], num[NW-1]} - {{(NW-15){1'b0}}, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        neg  <= span < 0;
        over <= span[SW-1:NW] != '0 && span >= 0;
        num  <= span[NW-1:0];
        rem  <= '0;
        quo  <= '0;
        step <= '0;
      end else if (busy) begin
        // shift one numerator bit, subtract where it fits
        num <= {num[NW-2:0], 1'b0};
        if (!trial[NW]) begin
          rem <= trial[NW-1:0];
          quo <= {quo[QW-2:0], 1'b1} | {QW{quo[QW-1]}} & {QW{1'b1}};
        end else begin
          rem <= {rem[NW-2:0], num[NW-1]};
          quo <= {quo[QW-2:0], 1'b0} | {QW{quo[QW-1]}};
        end
        step <= step + 1'b1;
        if (step == ($clog2(NW+1))'(NW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg) count = '0;
    else if (over || quo >= QW'(MAX_CELLS)) count = CW'(MAX_CELLS);
    else count = quo[CW-1:0];
  end
endmodule

// ===== hw/rtl/bogr_scan.sv =====
// 64 parallel cell comparators against one box per cycle.
module bogr_scan (
  input  logic signed [bogr_pkg::WIDE_W-1:0] x0,
  input  logic signed [bogr_pkg::WIDE_W-1:0] y0,
  input  logic [15:0] cs,
  input  logic [63:0] col_ok,
  input  logic signed [bogr_pkg::COORD_W-1:0] bx,
  input  logic signed [bogr_pkg::COORD_W-1:0] by,
  input  logic [bogr_pkg::EXT_W-1:0] bw,
  input  logic [bogr_pkg::EXT_W-1:0] bh,
  output logic [63:0] hits
);
  localparam int W = bogr_pkg::WIDE_W;
  logic signed [W-1:0] lx, hx, ly, hy, csw;
  logic yok;
  always_comb begin
    csw = W'(signed'({1'b0, cs}));
    lx = W'(bx);
    ly = W'(by);
    hx = lx + W'(signed'({1'b0, bw}));
    hy = ly + W'(signed'({1'b0, bh}));
    yok = (y0 < hy) && (y0 + csw > ly);
  end
  // each lane sits at x0 + k*cs
  for (genvar k = 0; k < 64; k++) begin : g_lane
    logic signed [W-1:0] cx;
    assign cx = x0 + W'(signed'({1'b0, cs} * 23'(k)));
    assign hits[k] = yok && col_ok[k] && (cx < hx) && (cx + csw > lx);
  end
endmodule

// ===== hw/rtl/box_occupancy_grid_rasterizer.sv =====
// Every command runs two count divisions (x, then y) before its result; a query whose
// row lies inside the grid also scans the stored boxes. busy stays high until the result
// strobe, so the next word can be accepted at the edge that takes the result.
// The two count divisions are 28-step (one quotient bit a cycle) and the box scan takes
// one stored box a cycle against 64 comparators; results cannot stall.
// Reset (rst, synchronous) empties the list and restores bounds and registers.
module box_occupancy_grid_rasterizer #(
  parameter int MAX_BOXES = bogr_pkg::MAX_BOXES_DEF,
  parameter int MAX_CELLS_PER_SIDE = bogr_pkg::MAX_CELLS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] cmd,
  input  logic signed [23:0] box_x,
  input  logic signed [23:0] box_y,
  input  logic [22:0] box_w,
  input  logic [22:0] box_h,
  input  logic [9:0] query_row,
  input  logic [3:0] query_word,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [19:0] cfg_data,
  output logic done,
  output logic [63:0] occupancy_bits,
  output logic signed [23:0] origin_x,
  output logic signed [23:0] origin_y,
  output logic [10:0] cells_across,
  output logic [10:0] cells_down,
  output logic [1:0] status
);
  localparam int W = bogr_pkg::WIDE_W;
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int NW = $clog2(MAX_BOXES+1);
  localparam int CW = $clog2(MAX_CELLS_PER_SIDE+1);
  localparam logic [2:0] S_IDLE = 3'd0, S_DX = 3'd1, S_DY = 3'd2, S_RD = 3'd3,
                         S_SCAN = 3'd4, S_OUT = 3'd5;

  logic [2:0] state;
  logic [15:0] cell_edge;
  logic [19:0] margin;
  logic [NW-1:0] box_count;
  logic signed [W-1:0] min_x, min_y, max_x, max_y;
  logic [47:0] corner_mem [MAX_BOXES];
  logic [45:0] extent_mem [MAX_BOXES];
  logic [47:0] corner_q;
  logic [45:0] extent_q;
  logic [NW-1:0] idx;
  logic [1:0] cmd_r;
  logic [9:0] row_r;
  logic [3:0] word_r;
  logic [1:0] st_r;
  logic [63:0] occ;
  logic [CW-1:0] nx, ny;
  logic signed [W-1:0] ox, oy, x0, y0, span;
  logic signed [W-1:0] add_hx, add_hy;
  logic [25:0] x_off, y_off;
  logic [15:0] cs;
  logic div_go, div_done;
  logic [CW-1:0] div_cnt;
  logic [63:0] col_ok, hits;
  logic rd_valid;

  assign busy = state != S_IDLE;
  assign cs = (cell_edge == 16'd0) ? 16'd1 : cell_edge;
  assign ox = min_x - W'(margin);
  assign oy = min_y - W'(margin);
  assign span = (state == S_DX) ? (max_x + W'(margin) - ox) : (max_y + W'(margin) - oy);

  // far corner of the incoming box
  assign add_hx = W'(box_x) + W'(signed'({1'b0, box_w}));
  assign add_hy = W'(box_y) + W'(signed'({1'b0, box_h}));

  bogr_div #(.MAX_CELLS(MAX_CELLS_PER_SIDE)) u_div (
    .clk, .rst, .go(div_go), .span, .divisor(cs), .done(div_done), .count(div_cnt)
  );

  assign x_off = 26'({word_r, 6'd0}) * 26'(cs);
  assign y_off = 26'(row_r) * 26'(cs);
  assign x0 = ox + W'(signed'({1'b0, x_off}));
  assign y0 = oy + W'(signed'({1'b0, y_off}));
  always_comb
    for (int k = 0; k < 64; k++)
      col_ok[k] = 32'({word_r, 6'd0}) + 32'(k) < 32'(nx);

  bogr_scan u_scan (
    .x0, .y0, .cs, .col_ok,
    .bx(corner_q[47:24]), .by(corner_q[23:0]),
    .bw(extent_q[45:23]), .bh(extent_q[22:0]), .hits
  );

  // store and registered read
  always_ff @(posedge clk) begin
    if (start && !busy && cmd == bogr_pkg::CMD_ADD && box_count < NW'(MAX_BOXES)) begin
      corner_mem[box_count[AW-1:0]] <= {box_x, box_y};
      extent_mem[box_count[AW-1:0]] <= {box_w, box_h};
    end
    corner_q <= corner_mem[idx[AW-1:0]];
    extent_q <= extent_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cell_edge <= 16'd32;
      margin <= 20'd320;
      box_count <= '0;
      min_x <= bogr_pkg::BOUND_INIT; min_y <= bogr_pkg::BOUND_INIT;
      max_x <= -bogr_pkg::BOUND_INIT; max_y <= -bogr_pkg::BOUND_INIT;
      done <= 1'b0;
      div_go <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      div_go <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == bogr_pkg::REG_CELL_EDGE) cell_edge <= cfg_data[15:0];
        else margin <= cfg_data;
      end
      case (state)
        S_IDLE: if (start) begin
          cmd_r <= cmd; row_r <= query_row; word_r <= query_word;
          st_r <= bogr_pkg::ST_OK;
          if (cmd == bogr_pkg::CMD_CLEAR) begin
            box_count <= '0;
            min_x <= bogr_pkg::BOUND_INIT; min_y <= bogr_pkg::BOUND_INIT;
            max_x <= -bogr_pkg::BOUND_INIT; max_y <= -bogr_pkg::BOUND_INIT;
          end else if (cmd == bogr_pkg::CMD_ADD) begin
            if (box_count >= NW'(MAX_BOXES)) st_r <= bogr_pkg::ST_FULL;
            else begin
              box_count <= box_count + 1'b1;
              if (W'(box_x) < min_x) min_x <= W'(box_x);
              if (W'(box_y) < min_y) min_y <= W'(box_y);
              if (add_hx > max_x) max_x <= add_hx;
              if (add_hy > max_y) max_y <= add_hy;
            end
          end
          div_go <= 1'b1;
          state <= S_DX;
        end
        S_DX: if (div_done) begin
          nx <= div_cnt; div_go <= 1'b1; state <= S_DY;
        end
        S_DY: if (div_done) begin
          ny <= div_cnt; occ <= '0; idx <= '0; rd_valid <= 1'b0;
          if (cmd_r == bogr_pkg::CMD_QUERY && 11'(row_r) < 11'(div_cnt)) state <= S_RD;
          else begin
            if (cmd_r == bogr_pkg::CMD_QUERY) st_r <= bogr_pkg::ST_ROW;
            state <= S_OUT;
          end
        end
        S_RD: begin
          // advance reads, accumulate one box per cycle
          if (rd_valid) occ <= occ | hits;
          if (idx < box_count) begin
            idx <= idx + 1'b1; rd_valid <= 1'b1;
          end else begin
            rd_valid <= 1'b0; state <= S_OUT;
          end
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign occupancy_bits = occ;
  assign origin_x = bogr_pkg::sat_coord(ox);
  assign origin_y = bogr_pkg::sat_coord(oy);
  assign cells_across = 11'(nx);
  assign cells_down = 11'(ny);
  assign status = st_r;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  typedef struct {
    logic [1:0] cmd;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [22:0] w;
    logic [22:0] h;
    logic [9:0] row;
    logic [3:0] word;
  } grid_cmd_t;

  typedef struct {
    logic [63:0] occ;
    logic signed [23:0] ox;
    logic signed [23:0] oy;
    logic [10:0] across;
    logic [10:0] down;
    logic [1:0] status;
  } grid_word_t;

  // Occupancy predictor and store of expected words
  class grid_scoreboard;
    longint corner_x[64], corner_y[64], ext_w[64], ext_h[64];
    int count;
    longint min_x, min_y, max_x, max_y;
    longint grid_pitch, margin_val;
    grid_word_t pending[$];
    int errors;

    function new();
      count = 0;
      grid_pitch = 32;
      margin_val = 320;
      errors = 0;
      clear_bounds();
    endfunction

    function void clear_bounds();
      min_x = 159984;
      min_y = 159984;
      max_x = -159984;
      max_y = -159984;
    endfunction

    function void write_reg(logic idx, logic [19:0] val);
      if (idx == bogr_pkg::REG_CELL_EDGE) grid_pitch = longint'(val[15:0]);
      else margin_val = longint'(val);
    endfunction

    function longint span_cells(longint lo, longint hi);
      longint cs;
      cs = (grid_pitch == 0) ? 1 : grid_pitch;
      if (hi < lo) return 0;
      return ((hi - lo) / cs > 1024) ? 1024 : (hi - lo) / cs;
    endfunction

    function logic signed [23:0] clamp24(longint v);
      if (v < -8388608) v = -8388608;
      if (v > 8388607) v = 8388607;
      return v[23:0];
    endfunction

    function longint rows_now();
      return span_cells(min_y - margin_val, max_y + margin_val);
    endfunction

    function longint cols_now();
      return span_cells(min_x - margin_val, max_x + margin_val);
    endfunction

    // Advance the state for one accepted word and queue its result
    function void note(grid_cmd_t c);
      grid_word_t r;
      longint cs, ox, oy, nx, ny, x0, y0, col;
      logic hit;
      cs = (grid_pitch == 0) ? 1 : grid_pitch;
      r.occ = '0;
      r.status = bogr_pkg::ST_OK;
      if (c.cmd == bogr_pkg::CMD_CLEAR) begin
        count = 0;
        clear_bounds();
      end else if (c.cmd == bogr_pkg::CMD_ADD) begin
        if (count >= 64) begin
          r.status = bogr_pkg::ST_FULL;
        end else begin
          corner_x[count] = longint'(c.x);
          corner_y[count] = longint'(c.y);
          ext_w[count] = longint'(c.w);
          ext_h[count] = longint'(c.h);
          if (corner_x[count] < min_x) min_x = corner_x[count];
          if (corner_y[count] < min_y) min_y = corner_y[count];
          if (corner_x[count] + ext_w[count] > max_x) max_x = corner_x[count] + ext_w[count];
          if (corner_y[count] + ext_h[count] > max_y) max_y = corner_y[count] + ext_h[count];
          count++;
        end
      end
      ox = min_x - margin_val;
      oy = min_y - margin_val;
      nx = span_cells(ox, max_x + margin_val);
      ny = span_cells(oy, max_y + margin_val);
      if (c.cmd == bogr_pkg::CMD_QUERY) begin
        if (longint'(c.row) >= ny) begin
          r.status = bogr_pkg::ST_ROW;
        end else begin
          y0 = oy + longint'(c.row) * cs;
          for (int k = 0; k < 64; k++) begin
            col = longint'(c.word) * 64 + k;
            x0 = ox + col * cs;
            hit = 1'b0;
            if (col < nx) begin
              for (int i = 0; i < count; i++) begin
                if (x0 < corner_x[i] + ext_w[i] && x0 + cs > corner_x[i] &&
                    y0 < corner_y[i] + ext_h[i] && y0 + cs > corner_y[i])
                  hit = 1'b1;
              end
            end
            r.occ[k] = hit;
          end
        end
      end
      r.ox = clamp24(ox);
      r.oy = clamp24(oy);
      r.across = nx[10:0];
      r.down = ny[10:0];
      pending.insert(pending.size(), r);
    endfunction

    function void check(grid_word_t got);
      grid_word_t exp_w;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.occ !== exp_w.occ) begin
        $error("occupancy_bits: expected %h, got %h", exp_w.occ, got.occ);
        errors++;
      end
      if (got.ox !== exp_w.ox) begin
        $error("origin_x: expected %0d, got %0d", exp_w.ox, got.ox);
        errors++;
      end
      if (got.oy !== exp_w.oy) begin
        $error("origin_y: expected %0d, got %0d", exp_w.oy, got.oy);
        errors++;
      end
      if (got.across !== exp_w.across) begin
        $error("cells_across: expected %0d, got %0d", exp_w.across, got.across);
        errors++;
      end
      if (got.down !== exp_w.down) begin
        $error("cells_down: expected %0d, got %0d", exp_w.down, got.down);
        errors++;
      end
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d, got %0d", exp_w.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] cmd = bogr_pkg::CMD_CLEAR;
  logic signed [23:0] box_x = '0;
  logic signed [23:0] box_y = '0;
  logic [22:0] box_w = '0;
  logic [22:0] box_h = '0;
  logic [9:0] query_row = '0;
  logic [3:0] query_word = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = bogr_pkg::REG_CELL_EDGE;
  logic [19:0] cfg_data = '0;
  logic done;
  logic [63:0] occupancy_bits;
  logic signed [23:0] origin_x, origin_y;
  logic [10:0] cells_across, cells_down;
  logic [1:0] status;

  grid_scoreboard sb;
  int sent;

  box_occupancy_grid_rasterizer i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .box_x(box_x), .box_y(box_y), .box_w(box_w), .box_h(box_h),
    .query_row(query_row), .query_word(query_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .occupancy_bits(occupancy_bits), .origin_x(origin_x),
    .origin_y(origin_y), .cells_across(cells_across), .cells_down(cells_down),
    .status(status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("box_occupancy_grid_rasterizer regression: fail");
    $finish;
  end

  // Check each strobed result word
  always @(posedge clk) begin
    grid_word_t got;
    if (!rst && done) begin
      got.occ = occupancy_bits;
      got.ox = origin_x;
      got.oy = origin_y;
      got.across = cells_across;
      got.down = cells_down;
      got.status = status;
      sb.check(got);
    end
  end

  // Issue one command word; start stays high when the next follows at once
  task automatic send(grid_cmd_t c);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c.cmd;
    box_x <= c.x;
    box_y <= c.y;
    box_w <= c.w;
    box_h <= c.h;
    query_row <= c.row;
    query_word <= c.word;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(c);
    sent++;
  endtask

  // Drain, then write one register while idle
  task automatic write_reg(logic idx, logic [19:0] val);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic grid_cmd_t mk(logic [1:0] op, int x, int y, int w, int h, int row,
                                   int word);
    grid_cmd_t c;
    c.cmd = op;
    c.x = x[23:0];
    c.y = y[23:0];
    c.w = w[22:0];
    c.h = h[22:0];
    c.row = row[9:0];
    c.word = word[3:0];
    return c;
  endfunction

  function automatic grid_cmd_t noise();
    return mk(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
  endfunction

  function automatic grid_cmd_t local_box();
    return mk(bogr_pkg::CMD_ADD, $urandom_range(0, 4000) - 2000,
              $urandom_range(0, 4000) - 2000,
              $urandom_range(0, 600), $urandom_range(0, 600), 0, 0);
  endfunction

  function automatic grid_cmd_t aimed_query();
    grid_cmd_t c;
    longint rows, cols;
    c = noise();
    c.cmd = bogr_pkg::CMD_QUERY;
    rows = sb.rows_now();
    cols = sb.cols_now();
    if (rows > 0 && $urandom_range(0, 99) < 85)
      c.row = 10'($urandom_range(0, 32'(rows - 1)));
    if (cols > 0 && $urandom_range(0, 99) < 80)
      c.word = 4'($urandom_range(0, 32'((cols - 1) / 64)));
    return c;
  endfunction

  initial begin
    int nbox, nq;
    logic [19:0] cs_pick [8];
    logic [19:0] mg_pick [6];
    cs_pick = '{20'd32, 20'd1, 20'd65535, 20'd16, 20'd0, 20'd7, 20'd100, 20'd48};
    mg_pick = '{20'd320, 20'd0, 20'd1048575, 20'd64, 20'd5, 20'd1000};
    sb = new();
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty grid, extremes, cell edges, unused command
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0));
    send(mk(bogr_pkg::CMD_UNUSED, -1, -1, 8388607, 8388607, 1023, 15));
    send(mk(bogr_pkg::CMD_ADD, 0, 0, 100, 100, 0, 0));
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 10, 0));
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 22, 0));
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 23, 0));
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 5, 1));
    send(mk(bogr_pkg::CMD_ADD, -224, -224, 32, 32, 0, 0));
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 3, 0));
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 4, 0));
    send(mk(bogr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send(mk(bogr_pkg::CMD_ADD, -8388608, -8388608, 0, 0, 0, 0));
    send(mk(bogr_pkg::CMD_ADD, 8388607, 8388607, 8388607, 8388607, 0, 0));
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0));
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 1023, 15));
    send(mk(bogr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send(mk(bogr_pkg::CMD_ADD, -8388608, 0, 8388607, 50, 0, 0));
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0));
    send(mk(bogr_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    send(mk(bogr_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 0));

    // Random: clear, 1-10 or 62-70 boxes, then mostly aimed queries
    for (int seq = 0; sent < 1600; seq++) begin
      if (seq % 8 == 7) begin
        write_reg(bogr_pkg::REG_CELL_EDGE,
                  ($urandom_range(0, 3) == 0) ? 20'($urandom_range(1, 65535)) :
                  cs_pick[$urandom_range(0, 7)]);
        write_reg(bogr_pkg::REG_MARGIN, ($urandom_range(0, 3) == 0) ? 20'($urandom) :
                  mg_pick[$urandom_range(0, 5)]);
      end
      send(mk(bogr_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom));
      nbox = ($urandom_range(0, 14) == 0) ? $urandom_range(62, 70) : $urandom_range(1, 10);
      for (int i = 0; i < nbox; i++) send(($urandom_range(0, 19) == 0) ? noise() : local_box());
      nq = $urandom_range(4, 12);
      for (int i = 0; i < nq; i++) send(($urandom_range(0, 9) == 0) ? noise() : aimed_query());
    end

    // Drain and let the block settle
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("box_occupancy_grid_rasterizer regression: pass");
    else
      $display("box_occupancy_grid_rasterizer regression: fail");
    $finish;
  end
endmodule
